@@ rtl/core/m4i_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package m4i_pkg;

  // cofactor, 2x2 minor and determinant accumulator widths
  localparam int CW = 100;
  localparam int MW = 66;
  localparam int DW = 136;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_COF,
    ST_DET,
    ST_DABS,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_ELEM,
    SRC_MINOR,
    SRC_COF
  } bsrc_t;

  typedef enum logic [1:0] {
    DST_MINOR,
    DST_COF,
    DST_DET
  } dst_t;

  typedef struct packed {
    logic [3:0] a_idx;
    logic [3:0] b_idx;
    bsrc_t      bsrc;
    logic [1:0] chunk;
    dst_t       dst;
    logic       clr;
    logic       neg;
  } mac_op_t;

  // element position of entry (t,u) of the 3x3 submatrix without row rr, col cc
  function automatic logic [3:0] s_idx(input logic [1:0] rr, input logic [1:0] cc,
                                       input logic [1:0] t, input logic [1:0] u);
    logic [1:0] row;
    logic [1:0] col;
    row = (t < rr) ? t : t + 2'd1;
    col = (u < cc) ? u : u + 2'd1;
    return {row, col};
  endfunction

  // one multiply-accumulate of cofactor ci: term j, sub-step sub (0..4)
  function automatic mac_op_t cof_op(input logic [3:0] ci, input logic [1:0] j,
                                     input logic [2:0] sub);
    mac_op_t    op;
    logic [1:0] rr;
    logic [1:0] cc;
    logic [1:0] u1;
    logic [1:0] u2;
    logic [2:0] k;
    rr = ci[3:2];
    cc = ci[1:0];
    u1 = (j == 2'd0) ? 2'd1 : 2'd0;
    u2 = (j == 2'd2) ? 2'd1 : 2'd2;
    k  = sub - 3'd2;
    op = '0;
    if (sub == 3'd0) begin
      op.a_idx = s_idx(rr, cc, 2'd1, u1);
      op.b_idx = s_idx(rr, cc, 2'd2, u2);
      op.bsrc  = SRC_ELEM;
      op.dst   = DST_MINOR;
      op.clr   = 1'b1;
    end else if (sub == 3'd1) begin
      op.a_idx = s_idx(rr, cc, 2'd1, u2);
      op.b_idx = s_idx(rr, cc, 2'd2, u1);
      op.bsrc  = SRC_ELEM;
      op.dst   = DST_MINOR;
      op.neg   = 1'b1;
    end else begin
      op.a_idx = s_idx(rr, cc, 2'd0, j);
      op.bsrc  = SRC_MINOR;
      op.chunk = k[1:0];
      op.dst   = DST_COF;
      op.clr   = (j == 2'd0) && (sub == 3'd2);
      op.neg   = (j == 2'd1) ^ rr[0] ^ cc[0];
    end
    return op;
  endfunction

  // determinant: row 0 element times its cofactor, one 32-bit chunk per step
  function automatic mac_op_t det_op(input logic [3:0] step);
    mac_op_t op;
    op       = '0;
    op.a_idx = {2'b00, step[3:2]};
    op.b_idx = {2'b00, step[3:2]};
    op.bsrc  = SRC_COF;
    op.chunk = step[1:0];
    op.dst   = DST_DET;
    op.clr   = (step == 4'd0);
    return op;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/m4i_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module m4i_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [m4i_pkg::CW-1:0]    mag,
  input  wire [m4i_pkg::DW-1:0]    den,
  output logic                     done,
  output logic [31:0]              quot,
  output logic                     over
);

  localparam int NW = m4i_pkg::CW + 2 * FRAC_BITS;
  localparam int TW = NW - 32;
  localparam int XW = (TW > m4i_pkg::DW) ? TW : m4i_pkg::DW;
  localparam int RW = m4i_pkg::DW + 1;

  logic [NW-1:0] num_w;
  logic [TW-1:0] top_w;
  logic          big_w;
  logic [RW-1:0] sh_w;
  logic          ge_w;

  logic          busy_r;
  logic          done_r;
  logic [4:0]    cnt_r;
  logic [RW-1:0] rem_r;
  logic [31:0]   qd_r;
  logic          big_r;

  assign num_w = {mag, {(2 * FRAC_BITS){1'b0}}};
  assign top_w = num_w[NW-1:32];
  // quotient reaches 2^32 exactly when the upper part alone covers the divisor
  assign big_w = XW'(top_w) >= XW'(den);

  assign sh_w = {rem_r[m4i_pkg::DW-1:0], qd_r[31]};
  assign ge_w = sh_w >= RW'(den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      big_r <= big_w;
      rem_r <= RW'(top_w);
      qd_r  <= num_w[31:0];
    end else if (busy_r) begin
      rem_r <= ge_w ? (sh_w - RW'(den)) : sh_w;
      qd_r  <= {qd_r[30:0], ge_w};
    end
  end

  assign done = done_r;
  assign quot = qd_r;
  assign over = big_r;

endmodule

`default_nettype wire

@@ rtl/core/matrix4_inverse_core.sv @@
// 4x4 matrix inverse, signed fixed point with FRAC_BITS fraction bits.
// input channel: sixteen elements of one matrix, row-major, one per beat on
//   in_elem_value. in_ready is high only while a matrix is being loaded.
// result channel: sixteen beats of the inverse in row-major order with
//   out_inv_index, out_inv_last on the sixteenth, out_singular when the
//   determinant is zero (values then zero) and out_saturated when a value
//   was clipped to the 32-bit range.
// after the sixteenth input beat a shared 33x33 multiply-accumulate unit
//   builds all cofactors and the determinant exactly in 256 operations,
//   each a read of a, a read of b, a multiply and an accumulate. each result
//   then takes one restoring division of 32 quotient bits.
// the block works on one matrix at a time and loads the next one after the
//   last result beat is taken.
// a stalled receiver simply holds the current result beat; nothing is lost.
// reset (rst_n low, synchronous) returns to loading with the element count
//   at zero.
`timescale 1ns / 1ps
`default_nettype none

module matrix4_inverse_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [31:0] in_elem_value,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_inv_value,
  output logic [3:0]  out_inv_index,
  output logic        out_inv_last,
  output logic        out_singular,
  output logic        out_saturated
);

  localparam int CW = m4i_pkg::CW;
  localparam int MW = m4i_pkg::MW;
  localparam int DW = m4i_pkg::DW;

  m4i_pkg::state_t  state_r, state_nxt;
  m4i_pkg::mac_op_t op;

  logic [3:0]  load_cnt_r;
  logic [1:0]  ph_r;
  logic [3:0]  ci_r;
  logic [1:0]  j_r;
  logic [2:0]  sub_r;
  logic [3:0]  step_r;
  logic [3:0]  oi_r;

  logic [31:0]   elem_mem [16];
  logic [3:0]    rd_addr;
  logic [31:0]   rd_q_r;
  logic [31:0]   a_r;
  logic [65:0]   prod_r;
  logic [MW-1:0] minor_r;
  logic [CW-1:0] cof_acc_r;
  logic [CW-1:0] cof_r [16];
  logic [DW-1:0] det_r;
  logic [DW-1:0] dmag_r;
  logic          det_neg_r;
  logic          sing_r;
  logic          neg_r;

  logic [31:0] val_r;
  logic        sat_r;

  logic          in_acc;
  logic          div_start;
  logic [3:0]    cof_addr;
  logic [CW-1:0] cof_rd;
  logic [CW-1:0] cof_mag;
  logic [95:0]   minor_x;
  logic [127:0]  cof_x;
  logic [31:0]   chunk_w;
  logic          chunk_ext;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic [DW-1:0] prod_ext;
  logic [DW-1:0] add_w;
  logic [MW-1:0] minor_base;
  logic [CW-1:0] cof_base;
  logic [DW-1:0] det_base;
  logic [MW-1:0] minor_nxt;
  logic [CW-1:0] cof_acc_nxt;
  logic [DW-1:0] det_nxt;
  logic          op_last;

  logic          div_done;
  logic [31:0]   div_quot;
  logic          div_over;
  logic [31:0]   limit_w;
  logic          sat_w;

  assign in_acc = in_valid && in_ready;

  assign op = (state_r == m4i_pkg::ST_DET) ? m4i_pkg::det_op(step_r)
                                            : m4i_pkg::cof_op(ci_r, j_r, sub_r);

  // element store: written while loading, one registered read port
  assign rd_addr = (ph_r == 2'd0) ? op.a_idx : op.b_idx;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      elem_mem[load_cnt_r] <= in_elem_value;
    end
    rd_q_r <= elem_mem[rd_addr];
  end

  assign cof_addr = (state_r == m4i_pkg::ST_DET) ? op.b_idx : {oi_r[1:0], oi_r[3:2]};
  assign cof_rd   = cof_r[cof_addr];
  assign cof_mag  = cof_rd[CW-1] ? (CW'(0) - cof_rd) : cof_rd;

  // second multiplier operand: element, or one 32-bit chunk of a wide value
  assign minor_x = {{(96 - MW){minor_r[MW-1]}}, minor_r};
  assign cof_x   = {{(128 - CW){cof_rd[CW-1]}}, cof_rd};

  always_comb begin
    chunk_w   = '0;
    chunk_ext = 1'b0;
    mul_b     = '0;
    unique case (op.bsrc)
      m4i_pkg::SRC_ELEM: begin
        mul_b = {rd_q_r[31], rd_q_r};
      end
      m4i_pkg::SRC_MINOR: begin
        chunk_w   = minor_x[{op.chunk, 5'd0} +: 32];
        chunk_ext = (op.chunk == 2'd2) ? chunk_w[31] : 1'b0;
        mul_b     = {chunk_ext, chunk_w};
      end
      m4i_pkg::SRC_COF: begin
        chunk_w   = cof_x[{op.chunk, 5'd0} +: 32];
        chunk_ext = (op.chunk == 2'd3) ? chunk_w[31] : 1'b0;
        mul_b     = {chunk_ext, chunk_w};
      end
      default: begin
        mul_b = '0;
      end
    endcase
  end

  assign mul_a = {a_r[31], a_r};

  assign prod_ext = {{(DW - 66){prod_r[65]}}, prod_r};
  assign add_w    = prod_ext << {op.chunk, 5'd0};

  assign minor_base  = op.clr ? '0 : minor_r;
  assign cof_base    = op.clr ? '0 : cof_acc_r;
  assign det_base    = op.clr ? '0 : det_r;
  assign minor_nxt   = op.neg ? (minor_base - add_w[MW-1:0]) : (minor_base + add_w[MW-1:0]);
  assign cof_acc_nxt = op.neg ? (cof_base - add_w[CW-1:0]) : (cof_base + add_w[CW-1:0]);
  assign det_nxt     = op.neg ? (det_base - add_w) : (det_base + add_w);

  assign op_last = (ph_r == 2'd3);

  // operation steps: read a, read b, multiply, accumulate
  always_ff @(posedge clk) begin
    if (state_r == m4i_pkg::ST_COF || state_r == m4i_pkg::ST_DET) begin
      if (ph_r == 2'd1) begin
        a_r <= rd_q_r;
      end
      if (ph_r == 2'd2) begin
        prod_r <= mul_a * mul_b;
      end
      if (op_last) begin
        unique case (op.dst)
          m4i_pkg::DST_MINOR: minor_r <= minor_nxt;
          m4i_pkg::DST_COF: begin
            cof_acc_r <= cof_acc_nxt;
            if (sub_r == 3'd4 && j_r == 2'd2) begin
              cof_r[ci_r] <= cof_acc_nxt;
            end
          end
          m4i_pkg::DST_DET: det_r <= det_nxt;
          default: ;
        endcase
      end
    end
    if (state_r == m4i_pkg::ST_DABS) begin
      dmag_r    <= det_r[DW-1] ? (DW'(0) - det_r) : det_r;
      det_neg_r <= det_r[DW-1];
      sing_r    <= (det_r == '0);
    end
    if (state_r == m4i_pkg::ST_DIV_GO) begin
      neg_r <= cof_rd[CW-1] ^ det_neg_r;
    end
    if (state_r == m4i_pkg::ST_DIV_WAIT && div_done) begin
      val_r <= sing_r ? 32'd0 : (sat_w ? limit_w : (neg_r ? (32'd0 - div_quot) : div_quot));
      sat_r <= !sing_r && sat_w;
    end
  end

  m4i_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (cof_mag),
    .den   (dmag_r),
    .done  (div_done),
    .quot  (div_quot),
    .over  (div_over)
  );

  assign limit_w = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign sat_w   = div_over || (div_quot > limit_w);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      m4i_pkg::ST_LOAD: begin
        if (in_acc && load_cnt_r == 4'd15) state_nxt = m4i_pkg::ST_COF;
      end
      m4i_pkg::ST_COF: begin
        if (op_last && sub_r == 3'd4 && j_r == 2'd2 && ci_r == 4'd15) begin
          state_nxt = m4i_pkg::ST_DET;
        end
      end
      m4i_pkg::ST_DET: begin
        if (op_last && step_r == 4'd15) state_nxt = m4i_pkg::ST_DABS;
      end
      m4i_pkg::ST_DABS:   state_nxt = m4i_pkg::ST_DIV_GO;
      m4i_pkg::ST_DIV_GO: state_nxt = m4i_pkg::ST_DIV_WAIT;
      m4i_pkg::ST_DIV_WAIT: begin
        if (div_done) state_nxt = m4i_pkg::ST_OUT;
      end
      m4i_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = (oi_r == 4'd15) ? m4i_pkg::ST_LOAD : m4i_pkg::ST_DIV_GO;
        end
      end
      default: state_nxt = m4i_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == m4i_pkg::ST_LOAD);
    out_valid = (state_r == m4i_pkg::ST_OUT);
    div_start = (state_r == m4i_pkg::ST_DIV_GO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= m4i_pkg::ST_LOAD;
      load_cnt_r <= '0;
      ph_r       <= '0;
      ci_r       <= '0;
      j_r        <= '0;
      sub_r      <= '0;
      step_r     <= '0;
      oi_r       <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        m4i_pkg::ST_LOAD: begin
          ph_r   <= '0;
          ci_r   <= '0;
          j_r    <= '0;
          sub_r  <= '0;
          step_r <= '0;
          if (in_acc) load_cnt_r <= load_cnt_r + 4'd1;
        end
        m4i_pkg::ST_COF: begin
          ph_r <= ph_r + 2'd1;
          if (op_last) begin
            if (sub_r == 3'd4) begin
              sub_r <= '0;
              if (j_r == 2'd2) begin
                j_r  <= '0;
                ci_r <= ci_r + 4'd1;
              end else begin
                j_r <= j_r + 2'd1;
              end
            end else begin
              sub_r <= sub_r + 3'd1;
            end
          end
        end
        m4i_pkg::ST_DET: begin
          ph_r <= ph_r + 2'd1;
          if (op_last) step_r <= step_r + 4'd1;
        end
        m4i_pkg::ST_DABS: oi_r <= '0;
        m4i_pkg::ST_OUT: begin
          if (out_ready) oi_r <= oi_r + 4'd1;
        end
        default: ;
      endcase
    end
  end

  assign out_inv_value = val_r;
  assign out_inv_index = oi_r;
  assign out_inv_last  = (oi_r == 4'd15);
  assign out_singular  = sing_r;
  assign out_saturated = sat_r;

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("load and result beats overlap");

  a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_inv_last |=> in_ready)
    else $error("no return to loading after last beat");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_inv_value == 32'd0 && !out_saturated)
    else $error("singular result not zero");

  a_count_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> load_cnt_r == 4'd0)
    else $error("element count not wrapped during results");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [191:0] wide_t;
  typedef logic [191:0] uwide_t;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  index;
    logic        last;
    logic        singular;
    logic        saturated;
  } inv_beat_t;

  class inverse_scoreboard;
    logic [31:0] elems[16];
    int unsigned load_pos;
    inv_beat_t   inv_q[$];
    int          fail_count;

    function new();
      load_pos = 0;
      fail_count = 0;
    endfunction

    function wide_t sext(logic [31:0] v);
      return {{160{v[31]}}, v};
    endfunction

    // signed cofactor of (rr, cc), exact
    function wide_t cofactor_of(wide_t m[16], int rr, int cc);
      wide_t s[9];
      wide_t acc;
      int k;
      k = 0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (i != rr && j != cc) begin
            s[k] = m[i*4+j];
            k++;
          end
        end
      end
      acc = s[0] * (s[4]*s[8] - s[5]*s[7]) - s[1] * (s[3]*s[8] - s[5]*s[6])
          + s[2] * (s[3]*s[7] - s[4]*s[6]);
      if (((rr + cc) & 1) != 0) acc = -acc;
      return acc;
    endfunction

    function void invert_store();
      wide_t m[16];
      wide_t cof[16];
      wide_t det;
      wide_t c;
      uwide_t dmag;
      uwide_t nmag;
      uwide_t quo;
      logic neg;
      logic [31:0] limit;
      inv_beat_t b;
      for (int i = 0; i < 16; i++) m[i] = sext(elems[i]);
      for (int i = 0; i < 16; i++) cof[i] = cofactor_of(m, i / 4, i % 4);
      det = '0;
      for (int i = 0; i < 4; i++) det = det + m[i] * cof[i];
      dmag = det[191] ? uwide_t'(-det) : uwide_t'(det);
      for (int i = 0; i < 16; i++) begin
        b.value = '0;
        b.index = i[3:0];
        b.last = (i == 15);
        b.singular = (det == '0);
        b.saturated = 1'b0;
        if (det != '0) begin
          c = cof[(i % 4) * 4 + i / 4];
          neg = c[191] ^ det[191];
          limit = neg ? 32'h8000_0000 : 32'h7fff_ffff;
          nmag = c[191] ? uwide_t'(-c) : uwide_t'(c);
          nmag = nmag << 32;
          quo = nmag / dmag;
          if ((|quo[191:32]) || quo[31:0] > limit) begin
            b.saturated = 1'b1;
            b.value = limit;
          end else begin
            b.value = neg ? -quo[31:0] : quo[31:0];
          end
        end
        inv_q.push_back(b);
      end
    endfunction

    function void note_elem(logic [31:0] v);
      elems[load_pos] = v;
      load_pos = (load_pos + 1) % 16;
      if (load_pos == 0) invert_store();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
    endtask

    task check_beat(inv_beat_t g);
      inv_beat_t w;
      if (inv_q.size() == 0) begin
        report("unexpected beat", g.value, 32'h0);
      end else begin
        w = inv_q.pop_front();
        if (g.value !== w.value) report("inv_value", g.value, w.value);
        if (g.index !== w.index) report("inv_index", g.index, w.index);
        if (g.last !== w.last) report("inv_last", g.last, w.last);
        if (g.singular !== w.singular) report("singular", g.singular, w.singular);
        if (g.saturated !== w.saturated) report("saturated", g.saturated, w.saturated);
      end
    endtask

    function int pending();
      return inv_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  wire         in_ready;
  logic [31:0] in_elem_value;
  wire         out_valid;
  logic        out_ready;
  wire  [31:0] out_inv_value;
  wire  [3:0]  out_inv_index;
  wire         out_inv_last;
  wire         out_singular;
  wire         out_saturated;

  inverse_scoreboard sb;
  int unsigned cycle_count;
  int unsigned stall_left;
  logic [31:0] mat[16];

  matrix4_inverse_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_elem_value(in_elem_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_inv_value(out_inv_value), .out_inv_index(out_inv_index),
    .out_inv_last(out_inv_last), .out_singular(out_singular),
    .out_saturated(out_saturated)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls, mostly short
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (cycle_count % 4000 < 1500) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    inv_beat_t g;
    if (rst_n && out_valid && out_ready) begin
      g.value = out_inv_value;
      g.index = out_inv_index;
      g.last = out_inv_last;
      g.singular = out_singular;
      g.saturated = out_saturated;
      sb.check_beat(g);
    end
  end

  task send_elem(logic [31:0] v, int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_elem_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_elem(v);
  endtask

  task send_matrix(bit bursty);
    for (int i = 0; i < 16; i++) send_elem(mat[i], bursty ? 0 : pick_gap());
  endtask

  function logic [31:0] rand_elem(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return $urandom_range(0, 64) - 32;
      default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
    endcase
  endfunction

  task fill_random();
    int kind;
    int shape;
    int a;
    int b;
    kind = $urandom_range(0, 3);
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 16; i++) mat[i] = rand_elem(kind);
    if (shape < 3) begin
      // diagonally dominant, well-conditioned
      for (int i = 0; i < 16; i++) mat[i] = rand_elem(1);
      for (int i = 0; i < 4; i++) mat[i*5] = mat[i*5] + ($urandom_range(0, 1) ?
        32'h0010_0000 : -32'h0010_0000);
    end else if (shape == 3) begin
      // repeated row
      a = $urandom_range(0, 3);
      b = (a + $urandom_range(1, 3)) % 4;
      for (int j = 0; j < 4; j++) mat[b*4+j] = mat[a*4+j];
    end else if (shape == 4) begin
      a = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) mat[i*4+a] = 32'h0;
    end
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_elem_value = '0;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // diagonal 2, -2, 1, -1 raw: positive clip, exact -2^31, clips both ways
    foreach (mat[i]) mat[i] = '0;
    mat[0] = 32'd2;
    mat[5] = -32'sd2;
    mat[10] = 32'd1;
    mat[15] = 32'hffff_ffff;
    send_matrix(1'b1);

    // extreme values with a repeated row: singular
    for (int i = 0; i < 16; i++) mat[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
    send_matrix(1'b0);

    for (int n = 0; n < 24; n++) begin
      if (n == 12) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      fill_random();
      send_matrix(n % 5 == 0);
    end

    // trailing partial matrix gives no beats
    for (int i = 0; i < 5; i++) send_elem($urandom, pick_gap());
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
